// ===== src/sprite_entry_expander_assert.svh =====
// ----------------------------------------------------------------------------
// sprite_entry_expander_assert.svh
// Assertion macros shared by the sprite entry expander queue and back end.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ENTRY_EXPANDER_ASSERT_SVH
`define SPRITE_ENTRY_EXPANDER_ASSERT_SVH

// Checked only while out of reset.
`define SPREX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPREX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sprex_pkg.sv =====
// ----------------------------------------------------------------------------
// sprex_pkg
// Types and constants of the sprite entry expander.
// ----------------------------------------------------------------------------
package sprex_pkg;

  localparam int unsigned TILE_W  = 12;
  localparam int unsigned BASE_W  = 11;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned QUAD_W  = 2;

  // attribute byte bits
  localparam int unsigned ATTR_DISABLE = 0;
  localparam int unsigned ATTR_DOUBLE  = 4;
  localparam int unsigned ATTR_FLIPX   = 5;

  // entries above this line are not drawn
  localparam logic [BYTE_W-1:0] CLIP_Y = 8'd16;

  // spacing of the tiles in a 2x2 block
  localparam logic [POS_W-1:0] QUAD_STEP = 9'd16;

  // last quadrant of a 2x2 block (bottom right)
  localparam logic [QUAD_W-1:0] QUAD_LAST = 2'd3;

  // classified entry, front to back
  typedef struct packed {
    logic                visible;
    logic                dbl;
    logic                flip;
    logic                set;
    logic [BASE_W-1:0]   base;
    logic [COLOR_W-1:0]  color;
    logic [BYTE_W-1:0]   xpos;
    logic [BYTE_W-1:0]   ypos;
    logic                last;
  } desc_t;

  // one tile draw command
  typedef struct packed {
    logic                visible;
    logic                set;
    logic [TILE_W-1:0]   tile;
    logic [COLOR_W-1:0]  color;
    logic                flip;
    logic [POS_W-1:0]    xpos;
    logic [POS_W-1:0]    ypos;
    logic                run_last;
    logic                list_end;
  } cmd_t;

endpackage

// ===== src/sprex_ifs.sv =====
// ----------------------------------------------------------------------------
// sprex_ifs
// Valid/ready channels: sprite list entries in, tile commands out.
// ----------------------------------------------------------------------------
interface sprex_in_if;
  logic       valid;
  logic       ready;
  logic       set_in;
  logic [7:0] code_in;
  logic [7:0] bank_color_in;
  logic [7:0] ypos_in;
  logic [7:0] xpos_in;
  logic [7:0] attr_in;
  logic       last_entry;

  modport source (
    output valid, set_in, code_in, bank_color_in, ypos_in, xpos_in, attr_in,
           last_entry,
    input  ready
  );
  modport sink (
    input  valid, set_in, code_in, bank_color_in, ypos_in, xpos_in, attr_in,
           last_entry,
    output ready
  );
endinterface

interface sprex_out_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic        set_out;
  logic [11:0] tile_number;
  logic [3:0]  color_out;
  logic        flip_out;
  logic [8:0]  xpos_out;
  logic [8:0]  ypos_out;
  logic        run_last;
  logic        list_end;

  modport source (
    output valid, visible, set_out, tile_number, color_out, flip_out, xpos_out,
           ypos_out, run_last, list_end,
    input  ready
  );
  modport sink (
    input  valid, visible, set_out, tile_number, color_out, flip_out, xpos_out,
           ypos_out, run_last, list_end,
    output ready
  );
endinterface

// ===== src/sprite_entry_expander.sv =====
// ----------------------------------------------------------------------------
// sprite_entry_expander
// Expands sprite list entries into 16x16 tile draw commands.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          carries
//  --------  ---  -----------------  ------------------------------------
//  in_chan   in   valid/ready        one five-byte entry, set, last flag
//  out_chan  out  valid/ready        one tile command per item
//
//  Commands: a plain, hidden or clipped entry gives one command, a double-size
//  entry four (one command per cycle from the back end's output register
//  while a descriptor waits and out_chan.ready is high). The first command
//  passes the front register, then a queue slot, then the output register.
//  Reset: synchronous, active low; clears handshake, queue and quadrant state only.
//  Stalls: out_chan.ready low holds the output register; the queue
//  (QUEUE_DEPTH entries) and the front register keep taking entries
//  until they fill.
//
// Entry layout handled in front:
//   attr bit 0 set, or y below 16   -> one blank command, visible = 0
//   attr bit 4 set                   -> 2x2 block, tiles base+0..3
//   attr bit 5 set                   -> flip; in a block left/right swap
//   base tile = code + (bank & 7) * 256, color = bank_color[7:4]
// ----------------------------------------------------------------------------
module sprite_entry_expander
  import sprex_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2  // 2 .. 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sprex_in_if.sink    in_chan,
  sprex_out_if.source out_chan
);

  // front -> queue
  logic  fr_vld;
  desc_t fr_desc;
  logic  fr_rdy;

  // queue -> back
  logic  hd_vld;
  desc_t hd_desc;
  logic  hd_pop;

  // classify and register the entry
  sprex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .desc_vld (fr_vld),
    .desc     (fr_desc),
    .desc_rdy (fr_rdy)
  );

  // decouples entry intake from command output
  sprex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fr_vld),
    .push_desc (fr_desc),
    .push_rdy  (fr_rdy),
    .pop_vld   (hd_vld),
    .pop_desc  (hd_desc),
    .pop_rdy   (hd_pop)
  );

  // head descriptor stays in the queue until its last command is loaded
  sprex_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (hd_vld),
    .head     (hd_desc),
    .head_pop (hd_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== src/sprex_front.sv =====
// ----------------------------------------------------------------------------
// sprex_front
// Takes entries, decides clipping and size, and registers a descriptor.
// ----------------------------------------------------------------------------
module sprex_front
  import sprex_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sprex_in_if.sink     in_chan,
  output logic         desc_vld,
  output desc_t        desc,
  input  logic         desc_rdy
);

  logic  vld_r, vld_nxt;
  desc_t desc_r, desc_nxt;
  logic  take;
  logic  hidden;

  assign in_chan.ready = !vld_r || desc_rdy;
  assign take          = in_chan.valid && in_chan.ready;

  // disabled by attribute, or above the visible area
  assign hidden = in_chan.attr_in[ATTR_DISABLE] || (in_chan.ypos_in < CLIP_Y);

  always_comb begin
    desc_nxt       = '0;
    desc_nxt.set   = in_chan.set_in;
    desc_nxt.last  = in_chan.last_entry;
    if (!hidden) begin
      desc_nxt.visible = 1'b1;
      desc_nxt.dbl     = in_chan.attr_in[ATTR_DOUBLE];
      desc_nxt.flip    = in_chan.attr_in[ATTR_FLIPX];
      desc_nxt.base    = {in_chan.bank_color_in[2:0], in_chan.code_in};
      desc_nxt.color   = in_chan.bank_color_in[7:4];
      desc_nxt.xpos    = in_chan.xpos_in;
      desc_nxt.ypos    = in_chan.ypos_in;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (desc_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= desc_nxt;
    end
  end

  assign desc_vld = vld_r;
  assign desc     = desc_r;

endmodule

// ===== src/sprex_queue.sv =====
// ----------------------------------------------------------------------------
// sprex_queue
// Small descriptor FIFO between the front and the back.
// ----------------------------------------------------------------------------
`include "sprite_entry_expander_assert.svh"

module sprex_queue
  import sprex_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_vld,
  input  desc_t push_desc,
  output logic  push_rdy,
  output logic  pop_vld,
  output desc_t pop_desc,
  input  logic  pop_rdy
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_rdy = (cnt_r != CNT_DEPTH);
  assign pop_vld  = (cnt_r != '0);
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;
  assign pop_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  `SPREX_ASSERT(a_q_cnt_bound, (cnt_r <= CNT_DEPTH), "queue count above depth")
  `SPREX_ASSERT_ALWAYS(a_q_rst_empty, (!rst_n |=> (cnt_r == '0 && !pop_vld)), "queue not empty after reset")

endmodule

// ===== src/sprex_back.sv =====
// ----------------------------------------------------------------------------
// sprex_back
// Walks descriptor quadrants; registers one command a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "sprite_entry_expander_assert.svh"

module sprex_back
  import sprex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  desc_t       head,
  output logic        head_pop,
  sprex_out_if.source out_chan
);

  logic              out_vld_r, out_vld_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [QUAD_W-1:0] quad_r, quad_nxt;
  logic [QUAD_W-1:0] tile_off;
  logic              load;
  logic              is_last;

  assign load     = head_vld && (!out_vld_r || out_chan.ready);
  assign is_last  = !head.dbl || (quad_r == QUAD_LAST);
  assign head_pop = load && is_last;

  // flip swaps left and right tiles of the block; a single tile keeps its code
  assign tile_off = quad_r ^ {1'b0, head.flip && head.dbl};

  always_comb begin
    cmd_nxt          = '0;
    cmd_nxt.visible  = head.visible;
    cmd_nxt.set      = head.set;
    cmd_nxt.tile     = {1'b0, head.base} + {{(TILE_W-QUAD_W){1'b0}}, tile_off};
    cmd_nxt.color    = head.color;
    cmd_nxt.flip     = head.flip;
    cmd_nxt.xpos     = {1'b0, head.xpos} + (quad_r[0] ? QUAD_STEP : '0);
    cmd_nxt.ypos     = {1'b0, head.ypos} + (quad_r[1] ? QUAD_STEP : '0);
    cmd_nxt.run_last = is_last;
    cmd_nxt.list_end = is_last && head.last;
  end

  always_comb begin
    quad_nxt    = quad_r;
    out_vld_nxt = out_vld_r;
    if (load) begin
      quad_nxt    = is_last ? '0 : quad_r + 1'b1;
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      quad_r    <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      quad_r    <= quad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.visible     = cmd_r.visible;
  assign out_chan.set_out     = cmd_r.set;
  assign out_chan.tile_number = cmd_r.tile;
  assign out_chan.color_out   = cmd_r.color;
  assign out_chan.flip_out    = cmd_r.flip;
  assign out_chan.xpos_out    = cmd_r.xpos;
  assign out_chan.ypos_out    = cmd_r.ypos;
  assign out_chan.run_last    = cmd_r.run_last;
  assign out_chan.list_end    = cmd_r.list_end;

  `SPREX_ASSERT(a_bk_mid_block, ((quad_r != '0) |-> (head_vld && head.dbl && head.visible)), "quadrant walk without a double-size entry")
  `SPREX_ASSERT(a_bk_hidden_one, ((out_vld_r && !cmd_r.visible) |-> (cmd_r.run_last && cmd_r.tile == '0)), "hidden entry gave more than a blank command")
  `SPREX_ASSERT(a_bk_end_last, ((out_vld_r && cmd_r.list_end) |-> cmd_r.run_last), "list end inside an entry")

endmodule
